[hw/rtl/grcn_pkg.sv]
// ----------------------------------------------------------------------------
// grcn_pkg: shared types and constants for the grid ray-cast core
// Register indexes, trig table, reset values and sequencer states.
// ----------------------------------------------------------------------------
package grcn_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	// configuration register indexes
	localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] REG_CELL_SIZE  = 3'd2;
	localparam logic [2:0] REG_MAP_WIDTH  = 3'd3;
	localparam logic [2:0] REG_MAP_HEIGHT = 3'd4;
	localparam logic [2:0] REG_MAX_RANGE  = 3'd5;

	localparam logic        OP_WRITE = 1'b0;
	localparam logic        OP_QUERY = 1'b1;
	localparam logic        KIND_HIT = 1'b0;
	localparam logic        KIND_SUM = 1'b1;

	localparam logic [15:0] CELL_SIZE_RST = 16'd51;
	localparam logic [8:0]  MAP_DIM_RST   = 9'd256;
	localparam logic [15:0] MAX_RANGE_RST = 16'd10240;
	localparam logic [16:0] STEP_EXTRA    = 17'd10;
	localparam logic [16:0] NONE_DIST     = 17'd102400;
	localparam logic [23:0] NONE_POS      = 24'd102400;
	localparam logic [3:0]  LAST_RAY      = 4'd11;
	localparam logic [30:0] Q14_HALF      = 31'd8192;

	// dividend width: offset from origin of an in-front sample
	localparam int DIV_NW = 25;
	localparam int DIV_DW = 16;

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_MUL   = 10'b0000000100,
		ST_CHK   = 10'b0000001000,
		ST_DIV   = 10'b0000010000,
		ST_IDX   = 10'b0000100000,
		ST_RD    = 10'b0001000000,
		ST_HIT   = 10'b0010000000,
		ST_EMIT  = 10'b0100000000,
		ST_SUM   = 10'b1000000000
	} state_t;

	// Q14 magnitude of cos(k*30 deg)
	function automatic logic [14:0] cos_mag(input logic [3:0] k);
		case (k)
			4'd0, 4'd6:                  cos_mag = 15'd16384;
			4'd1, 4'd5, 4'd7, 4'd11:     cos_mag = 15'd14189;
			4'd2, 4'd4, 4'd8, 4'd10:     cos_mag = 15'd8192;
			default:                     cos_mag = 15'd0;
		endcase
	endfunction

	function automatic logic cos_neg(input logic [3:0] k);
		cos_neg = (k >= 4'd4) && (k <= 4'd8);
	endfunction

	// Q14 magnitude of sin(k*30 deg)
	function automatic logic [14:0] sin_mag(input logic [3:0] k);
		case (k)
			4'd3, 4'd9:                  sin_mag = 15'd16384;
			4'd2, 4'd4, 4'd8, 4'd10:     sin_mag = 15'd14189;
			4'd1, 4'd5, 4'd7, 4'd11:     sin_mag = 15'd8192;
			default:                     sin_mag = 15'd0;
		endcase
	endfunction

	function automatic logic sin_neg(input logic [3:0] k);
		sin_neg = (k >= 4'd7) && (k <= 4'd11);
	endfunction

	// clamp a 26-bit signed coordinate to 24 bits
	function automatic logic [23:0] sat24(input logic signed [25:0] v);
		if (v > 26'sd8388607)
			sat24 = 24'h7FFFFF;
		else if (v < -26'sd8388608)
			sat24 = 24'h800000;
		else
			sat24 = v[23:0];
	endfunction

endpackage

[hw/rtl/grcn_div.sv]
// ----------------------------------------------------------------------------
// grcn_div: restoring divider
// One quotient bit per cycle; quotient valid once busy drops.
// ----------------------------------------------------------------------------
module grcn_div
	import grcn_pkg::*;
#(
	parameter int NW = DIV_NW,
	parameter int DW = DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [NW-1:0] quotient
);
	localparam int CW = (NW > 1) ? $clog2(NW) : 1;

	logic          run_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   shifted;
	logic          fits;

	// trial subtract of the shifted remainder
	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(NW - 1);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy     = run_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/grcn_map.sv]
// ----------------------------------------------------------------------------
// grcn_map: one-bit occupancy store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module grcn_map
	import grcn_pkg::*;
#(
	parameter int DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic              wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic              rdata
);
	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[hw/rtl/grid_ray_cast_nearest_obstacle_core.sv]
// ----------------------------------------------------------------------------
// grid_ray_cast_nearest_obstacle_core: occupancy-grid ray caster
// A write item updates the map in the cycle it is accepted. A query samples
// 12 rays; an in-map sample passes through multiply, origin check, divide,
// index, map read and hit check, while a sample left of or below the origin
// stops after the origin check. Reset starts a clearing pass over every cell;
// no item is accepted until it ends. Config registers reset to their defaults.
// ----------------------------------------------------------------------------
module grid_ray_cast_nearest_obstacle_core
	import grcn_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [15:0] cell_index,
	input  logic signed [7:0]  cell_value,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic        last_person,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [3:0]  ray_index,
	output logic signed [23:0] hit_x,
	output logic signed [23:0] hit_y,
	output logic [16:0] distance,
	output logic        found,
	output logic        batch_end,
	output logic        last
);
	localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WE_W   = $clog2(MAX_WIDTH + 1);
	localparam int HE_W   = $clog2(MAX_HEIGHT + 1);

	// configuration registers
	logic signed [23:0] origin_x_q, origin_y_q;
	logic [15:0] cell_size_q, max_range_q;
	logic [8:0]  map_width_q, map_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			cell_size_q  <= CELL_SIZE_RST;
			map_width_q  <= MAP_DIM_RST;
			map_height_q <= MAP_DIM_RST;
			max_range_q  <= MAX_RANGE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ORIGIN_X:   origin_x_q   <= cfg_wdata;
				REG_ORIGIN_Y:   origin_y_q   <= cfg_wdata;
				REG_CELL_SIZE:  cell_size_q  <= cfg_wdata[15:0];
				REG_MAP_WIDTH:  map_width_q  <= cfg_wdata[8:0];
				REG_MAP_HEIGHT: map_height_q <= cfg_wdata[8:0];
				REG_MAX_RANGE:  max_range_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// derived config
	logic [WE_W-1:0] w_eff;
	logic [HE_W-1:0] h_eff;
	logic [15:0]     cs_eff;
	logic [16:0]     step;

	assign w_eff  = (32'(map_width_q) > 32'(MAX_WIDTH)) ? WE_W'(MAX_WIDTH)
	                                                     : WE_W'(map_width_q);
	assign h_eff  = (32'(map_height_q) > 32'(MAX_HEIGHT)) ? HE_W'(MAX_HEIGHT)
	                                                       : HE_W'(map_height_q);
	assign cs_eff = (cell_size_q == '0) ? 16'd1 : cell_size_q;
	assign step   = {1'b0, cell_size_q} + STEP_EXTRA;

	// sequencer state
	state_t state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [3:0]  ray_q;
	logic [17:0] d_q;
	logic signed [23:0] px_q, py_q;
	logic        batch_q;
	logic signed [25:0] xs_q, ys_q;
	logic [ADDR_W-1:0] idx_q;
	logic        inb_q;
	logic        any_q;
	logic [16:0] best_d_q;
	logic [3:0]  best_ray_q;
	logic [23:0] best_x_q, best_y_q;

	// output slot
	logic        out_valid_q;
	logic        slot_free;
	assign slot_free = !out_valid_q || out_ready;

	// accepted items
	logic acc;
	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	function automatic logic signed [25:0] pos_ext(input logic signed [23:0] p);
		pos_ext = {{2{p[23]}}, p};
	endfunction

	// sample point: pos + round(trig * d)
	logic [30:0] prod_x, prod_y;
	logic [16:0] rnd_x, rnd_y;
	logic signed [25:0] off_x, off_y, nxt_x, nxt_y;

	assign prod_x = 31'(cos_mag(ray_q)) * 31'(d_q[15:0]);
	assign prod_y = 31'(sin_mag(ray_q)) * 31'(d_q[15:0]);
	assign rnd_x  = 17'((prod_x + Q14_HALF) >> 14);
	assign rnd_y  = 17'((prod_y + Q14_HALF) >> 14);
	assign off_x  = cos_neg(ray_q) ? -$signed({9'd0, rnd_x}) : $signed({9'd0, rnd_x});
	assign off_y  = sin_neg(ray_q) ? -$signed({9'd0, rnd_y}) : $signed({9'd0, rnd_y});
	assign nxt_x  = 26'(pos_ext(px_q)) + off_x;
	assign nxt_y  = 26'(pos_ext(py_q)) + off_y;

	// offset from origin
	logic signed [26:0] dx, dy;
	assign dx = {xs_q[25], xs_q} - {{3{origin_x_q[23]}}, origin_x_q};
	assign dy = {ys_q[25], ys_q} - {{3{origin_y_q[23]}}, origin_y_q};

	// dividers for column and row
	logic div_start, busy_x, busy_y;
	logic [DIV_NW-1:0] col_quo, row_quo;

	assign div_start = (state_q == ST_CHK) && !dx[26] && !dy[26];

	grcn_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_col (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(dx[DIV_NW-1:0]), .divisor(cs_eff),
		.busy(busy_x), .quotient(col_quo)
	);

	grcn_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_row (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(dy[DIV_NW-1:0]), .divisor(cs_eff),
		.busy(busy_y), .quotient(row_quo)
	);

	// cell index and bounds
	logic in_bounds;
	logic [ADDR_W-1:0] cell_addr;
	assign in_bounds = (32'(col_quo) < 32'(w_eff)) && (32'(row_quo) < 32'(h_eff));
	assign cell_addr = ADDR_W'(32'(row_quo[ROW_W-1:0]) * 32'(w_eff)
	                           + 32'(col_quo[COL_W-1:0]));

	// occupancy store
	logic map_we, map_wd, map_rd;
	assign map_we = (state_q == ST_CLEAR) ||
	                (acc && (opcode == OP_WRITE) && (32'(cell_index) < 32'(CELLS)));
	assign map_wd = (state_q == ST_CLEAR) ? 1'b0 : (!cell_value[7] && (cell_value != '0));

	grcn_map #(.DEPTH(CELLS), .ADDR_W(ADDR_W)) u_map (
		.clk(clk), .we(map_we),
		.waddr((state_q == ST_CLEAR) ? clr_q : ADDR_W'(cell_index)),
		.wdata(map_wd), .re(state_q == ST_RD), .raddr(idx_q), .rdata(map_rd)
	);

	// ray stepping helpers
	logic [17:0] d_next;
	logic        in_range;
	assign d_next   = d_q + {1'b0, step};
	assign in_range = d_q < {2'b0, max_range_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			ray_q   <= '0;
			d_q     <= '0;
			any_q   <= 1'b0;
			best_d_q   <= NONE_DIST;
			best_ray_q <= '0;
			best_x_q   <= NONE_POS;
			best_y_q   <= NONE_POS;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == 32'(CELLS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc && opcode == OP_QUERY) begin
						ray_q      <= '0;
						d_q        <= '0;
						any_q      <= 1'b0;
						best_d_q   <= NONE_DIST;
						best_ray_q <= '0;
						best_x_q   <= NONE_POS;
						best_y_q   <= NONE_POS;
						state_q    <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (in_range) begin
						state_q <= ST_CHK;
					end else if (ray_q == LAST_RAY) begin
						state_q <= ST_SUM;
					end else begin
						ray_q <= ray_q + 1'b1;
						d_q   <= '0;
					end
				end
				ST_CHK: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						d_q     <= d_next;
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					if (!busy_x && !busy_y)
						state_q <= ST_IDX;
				end
				ST_IDX: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					if (inb_q) begin
						state_q <= ST_HIT;
					end else begin
						d_q     <= d_next;
						state_q <= ST_MUL;
					end
				end
				ST_HIT: begin
					if (map_rd) begin
						state_q <= ST_EMIT;
					end else begin
						d_q     <= d_next;
						state_q <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if ({1'b0, best_d_q} > d_q) begin
							best_d_q   <= d_q[16:0];
							best_ray_q <= ray_q;
							best_x_q   <= sat24(xs_q);
							best_y_q   <= sat24(ys_q);
							any_q      <= 1'b1;
						end
						if (ray_q == LAST_RAY) begin
							state_q <= ST_SUM;
						end else begin
							ray_q   <= ray_q + 1'b1;
							d_q     <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_SUM: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc && opcode == OP_QUERY) begin
			px_q    <= pos_x;
			py_q    <= pos_y;
			batch_q <= last_person;
		end
		if (state_q == ST_MUL) begin
			xs_q <= nxt_x;
			ys_q <= nxt_y;
		end
		if (state_q == ST_IDX) begin
			idx_q <= cell_addr;
			inb_q <= in_bounds;
		end
	end

	// output register
	logic load_hit, load_sum;
	assign load_hit = (state_q == ST_EMIT) && slot_free;
	assign load_sum = (state_q == ST_SUM) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_hit || load_sum)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_hit) begin
			kind      <= KIND_HIT;
			ray_index <= ray_q;
			hit_x     <= sat24(xs_q);
			hit_y     <= sat24(ys_q);
			distance  <= d_q[16:0];
			found     <= 1'b1;
			batch_end <= 1'b0;
			last      <= 1'b0;
		end else if (load_sum) begin
			kind      <= KIND_SUM;
			ray_index <= best_ray_q;
			hit_x     <= best_x_q;
			hit_y     <= best_y_q;
			distance  <= best_d_q;
			found     <= any_q;
			batch_end <= batch_q;
			last      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the grid ray-cast nearest-obstacle core
// A directed table and then random phases of cell writes and queries, under
// several map settings. Results are checked field by field against a local
// model of the caster that tracks the occupancy grid and the registers.
// ----------------------------------------------------------------------------
module tb_top;
	import grcn_pkg::*;

	localparam int STORE_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam longint CYCLE_LIMIT = 6000000;
	localparam int RANDOM_ITEMS = 300;

	typedef struct packed {
		logic        kind;
		logic [3:0]  ray;
		logic [23:0] hx;
		logic [23:0] hy;
		logic [16:0] dst;
		logic        found;
		logic        be;
		logic        lst;
	} ray_result_t;

	// one directed item; a typed summary is given where it is obvious
	typedef struct packed {
		logic        op;
		logic [15:0] idx;
		logic [7:0]  val;
		logic [23:0] x;
		logic [23:0] y;
		logic        lp;
		logic        typed;
		logic [3:0]  t_ray;
		logic [23:0] t_x;
		logic [23:0] t_y;
		logic [16:0] t_dist;
		logic        t_found;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_addr;
	logic [23:0] cfg_wdata;
	logic in_valid, in_ready;
	logic opcode;
	logic [15:0] cell_index;
	logic signed [7:0] cell_value;
	logic signed [23:0] pos_x, pos_y;
	logic last_person;
	logic out_valid, out_ready;
	logic kind;
	logic [3:0] ray_index;
	logic signed [23:0] hit_x, hit_y;
	logic [16:0] distance;
	logic found, batch_end, last;

	grid_ray_cast_nearest_obstacle_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.cell_index(cell_index), .cell_value(cell_value), .pos_x(pos_x),
		.pos_y(pos_y), .last_person(last_person),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.ray_index(ray_index), .hit_x(hit_x), .hit_y(hit_y),
		.distance(distance), .found(found), .batch_end(batch_end), .last(last)
	);

	// shadow of the grid and registers
	bit occ_grid [STORE_CELLS];
	longint org_x, org_y;
	int unsigned csz, map_w, map_h, ray_range;
	ray_result_t pending_results[$];

	int errors;
	int n_queries, n_writes, n_hits, n_summaries_found, n_phases;
	longint cycles;
	int burst_left;

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycles, pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Q14 trig table
	function automatic int cos_q14(int k);
		int t [12];
		t = '{16384, 14189, 8192, 0, -8192, -14189, -16384, -14189, -8192, 0,
			8192, 14189};
		return t[k];
	endfunction

	function automatic int sin_q14(int k);
		return cos_q14((k + 9) % 12);
	endfunction

	// product rounded half away from zero
	function automatic longint round_q14(int c, int unsigned d);
		longint mag;
		longint r;
		mag = (c < 0) ? -c : c;
		r = (mag * longint'(d) + 8192) >>> 14;
		return (c < 0) ? -r : r;
	endfunction

	function automatic logic [23:0] clamp24(longint v);
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v[23:0];
	endfunction

	// world point to grid index; returns 0 when off the map
	function automatic bit locate_cell(longint x, longint y, output int idx);
		longint cs, w, h, col, row;
		cs = (csz == 0) ? 1 : csz;
		w = (map_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : map_w;
		h = (map_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : map_h;
		idx = 0;
		if (x < org_x || y < org_y)
			return 0;
		col = (x - org_x) / cs;
		row = (y - org_y) / cs;
		if (col >= w || row >= h)
			return 0;
		idx = int'(row * w + col);
		return 1;
	endfunction

	// update the grid or cast the 12 rays, queueing the expected results
	task automatic predict_item(logic op, logic [15:0] idx, logic signed [7:0] val,
			logic signed [23:0] px, logic signed [23:0] py, logic lp);
		ray_result_t r;
		ray_result_t best;
		longint x, y;
		int unsigned d, step;
		int grid_idx;
		bit any;
		if (op == OP_WRITE) begin
			occ_grid[idx] = (val > 0);
			n_writes++;
			return;
		end
		n_queries++;
		any = 0;
		step = csz + 10;
		best = '{kind: KIND_SUM, ray: 4'd0, hx: NONE_POS, hy: NONE_POS,
			dst: NONE_DIST, found: 1'b0, be: lp, lst: 1'b1};
		for (int k = 0; k < 12; k++) begin
			for (d = 0; d < ray_range; d += step) begin
				x = longint'(px) + round_q14(cos_q14(k), d);
				y = longint'(py) + round_q14(sin_q14(k), d);
				if (!locate_cell(x, y, grid_idx))
					continue;
				if (occ_grid[grid_idx]) begin
					r = '{kind: KIND_HIT, ray: k[3:0], hx: clamp24(x), hy: clamp24(y),
						dst: d[16:0], found: 1'b1, be: 1'b0, lst: 1'b0};
					pending_results = {pending_results, r};
					if (d < best.dst) begin
						best.ray = k[3:0];
						best.hx = r.hx;
						best.hy = r.hy;
						best.dst = d[16:0];
						best.found = 1'b1;
						any = 1;
					end
					break;
				end
			end
		end
		if (any)
			n_summaries_found++;
		pending_results = {pending_results, best};
	endtask

	// config write, applied to the shadow registers too
	task automatic write_reg(logic [2:0] addr, logic [23:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		case (addr)
			REG_ORIGIN_X:   org_x = longint'(signed'(data));
			REG_ORIGIN_Y:   org_y = longint'(signed'(data));
			REG_CELL_SIZE:  csz = data[15:0];
			REG_MAP_WIDTH:  map_w = data[8:0];
			REG_MAP_HEIGHT: map_h = data[8:0];
			REG_MAX_RANGE:  ray_range = data[15:0];
			default: ;
		endcase
	endtask

	task automatic set_map(longint ox, longint oy, int unsigned cs, int unsigned w,
			int unsigned h, int unsigned rng);
		write_reg(REG_ORIGIN_X, ox[23:0]);
		write_reg(REG_ORIGIN_Y, oy[23:0]);
		write_reg(REG_CELL_SIZE, cs[23:0]);
		write_reg(REG_MAP_WIDTH, w[23:0]);
		write_reg(REG_MAP_HEIGHT, h[23:0]);
		write_reg(REG_MAX_RANGE, rng[23:0]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop sending, wait for every expected result, then let the core settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// drive one item in bursts with random gaps; returns once accepted
	task automatic send_item(logic op, logic [15:0] idx, logic [7:0] val,
			logic [23:0] px, logic [23:0] py, logic lp);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		cell_index <= idx;
		cell_value <= val;
		pos_x <= px;
		pos_y <= py;
		last_person <= lp;
		do
			@(posedge clk);
		while (!in_ready);
		predict_item(op, idx, val, px, py, lp);
	endtask

	// receiver stalls: out_ready follows one of four randomly chosen modes
	int stall_mode;
	always @(negedge clk) begin
		if (cycles % 64 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= (cycles % 4 == 0);
			default: out_ready <= ($urandom_range(0, 9) != 0);
		endcase
	end

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		ray_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result item, kind", kind, 0);
			end else begin
				want = pending_results.pop_front();
				if (kind == KIND_HIT)
					n_hits++;
				if (kind !== want.kind) report("kind", kind, want.kind);
				if (ray_index !== want.ray) report("ray_index", ray_index, want.ray);
				if (hit_x !== want.hx) report("hit_x", hit_x, want.hx);
				if (hit_y !== want.hy) report("hit_y", hit_y, want.hy);
				if (distance !== want.dst) report("distance", distance, want.dst);
				if (found !== want.found) report("found", found, want.found);
				if (batch_end !== want.be) report("batch_end", batch_end, want.be);
				if (last !== want.lst) report("last", last, want.lst);
			end
		end
	end

	function automatic logic [23:0] clamp_pos(longint v);
		return clamp24(v);
	endfunction

	// main sequence
	initial begin
		dir_row_t rows [10];
		int items;
		int phase;
		int unsigned w, h, cs, rng, nsamp, n_in_phase;
		longint ox, oy, px, py;
		logic [15:0] idx;

		errors = 0;
		cycles = 0;
		burst_left = 0;
		stall_mode = 0;
		n_queries = 0;
		n_writes = 0;
		n_hits = 0;
		n_summaries_found = 0;
		n_phases = 0;
		org_x = 0;
		org_y = 0;
		csz = CELL_SIZE_RST;
		map_w = MAP_DIM_RST;
		map_h = MAP_DIM_RST;
		ray_range = MAX_RANGE_RST;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_ORIGIN_X;
		cfg_wdata = '0;
		in_valid = 1'b0;
		opcode = OP_WRITE;
		cell_index = '0;
		cell_value = '0;
		pos_x = '0;
		pos_y = '0;
		last_person = 1'b0;
		out_ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// reset state: empty grid, default registers
		send_item(OP_QUERY, 16'd0, 8'd0, 24'd0, 24'd0, 1'b0);
		send_item(OP_QUERY, 16'd0, 8'd0, 24'h800000, 24'h800000, 1'b1);
		drain();
		set_map(0, 0, 1000, 16, 16, 5000);

		// directed table on a small 16x16 grid of 1 m cells
		rows = '{
			'{OP_WRITE, 16'd0, 8'h80, 24'd0, 24'd0, 1'b0, 1'b0, 4'd0, 24'd0, 24'd0, 17'd0, 1'b0},
			'{OP_QUERY, 16'hFFFF, 8'h7F, 24'd0, 24'd0, 1'b0,
				1'b1, 4'd0, NONE_POS, NONE_POS, NONE_DIST, 1'b0},
			'{OP_WRITE, 16'd0, 8'h7F, 24'd0, 24'd0, 1'b0, 1'b0, 4'd0, 24'd0, 24'd0, 17'd0, 1'b0},
			'{OP_QUERY, 16'd0, 8'd0, 24'd0, 24'd0, 1'b1,
				1'b1, 4'd0, 24'd0, 24'd0, 17'd0, 1'b1},
			'{OP_WRITE, 16'hFFFF, 8'h01, 24'd0, 24'd0, 1'b1, 1'b0, 4'd0, 24'd0, 24'd0, 17'd0, 1'b0},
			'{OP_WRITE, 16'd0, 8'hFF, 24'd0, 24'd0, 1'b0, 1'b0, 4'd0, 24'd0, 24'd0, 17'd0, 1'b0},
			'{OP_WRITE, 16'd3, 8'h01, 24'd0, 24'd0, 1'b0, 1'b0, 4'd0, 24'd0, 24'd0, 17'd0, 1'b0},
			'{OP_QUERY, 16'd0, 8'd0, 24'd0, 24'd0, 1'b0, 1'b0, 4'd0, 24'd0, 24'd0, 17'd0, 1'b0},
			'{OP_QUERY, 16'd0, 8'd0, 24'h800000, 24'h800000, 1'b1,
				1'b1, 4'd0, NONE_POS, NONE_POS, NONE_DIST, 1'b0},
			'{OP_QUERY, 16'd0, 8'd0, 24'h7FFFFF, 24'h7FFFFF, 1'b0,
				1'b1, 4'd0, NONE_POS, NONE_POS, NONE_DIST, 1'b0}
		};
		foreach (rows[i]) begin
			send_item(rows[i].op, rows[i].idx, rows[i].val, rows[i].x, rows[i].y, rows[i].lp);
			if (rows[i].typed)
				pending_results[pending_results.size() - 1] = '{kind: KIND_SUM,
					ray: rows[i].t_ray, hx: rows[i].t_x, hy: rows[i].t_y,
					dst: rows[i].t_dist, found: rows[i].t_found, be: rows[i].lp,
					lst: 1'b1};
		end

		// random phases, each with its own map settings
		items = 0;
		phase = 0;
		while (items < RANDOM_ITEMS) begin
			drain();
			case (phase)
				0: begin
					// largest cell and range: only the ray origin is sampled
					ox = -8388608; oy = -8388608; cs = 65535; w = 256; h = 256; rng = 65535;
				end
				1: begin
					// zero cell size and zero range
					ox = 0; oy = 0; cs = 0; w = 16; h = 16; rng = 0;
				end
				2: begin
					// zero width, oversized height
					ox = 0; oy = 0; cs = 300; w = 0; h = 511; rng = 1500;
				end
				3: begin
					// grid near the top of the coordinate range: hit points clamp
					ox = 8388607 - 200; oy = 8388607 - 200; cs = 1; w = 256; h = 256;
					rng = 120;
				end
				4: begin
					// oversized width, smallest height
					ox = -5000; oy = 0; cs = 700; w = 400; h = 1; rng = 4000;
				end
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						ox = longint'(signed'(24'($urandom)));
						oy = longint'(signed'(24'($urandom)));
					end else begin
						ox = longint'($urandom_range(0, 200000)) - 100000;
						oy = longint'($urandom_range(0, 200000)) - 100000;
					end
					cs = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 65535)
						: $urandom_range(20, 2000);
					w = $urandom_range(1, 24);
					h = $urandom_range(1, 24);
					if ($urandom_range(0, 4) == 0) w = $urandom_range(1, 256);
					if ($urandom_range(0, 4) == 0) h = $urandom_range(1, 256);
					nsamp = $urandom_range(1, 8);
					rng = (cs + 10) * nsamp;
					if (rng > 65535) rng = 65535;
					rng = rng - $urandom_range(0, rng - 1);
				end
			endcase
			set_map(ox, oy, cs, w, h, rng);
			n_phases++;
			n_in_phase = $urandom_range(12, 30);
			for (int j = 0; j < n_in_phase && items < RANDOM_ITEMS; j++) begin
				if ($urandom_range(0, 1) == 0) begin
					// cell write, mostly inside the grid in use
					if ($urandom_range(0, 9) == 0 || w == 0 || h == 0)
						idx = 16'($urandom);
					else
						idx = 16'($urandom_range(0, ((w > 256 ? 256 : w) *
							(h > 256 ? 256 : h)) - 1));
					send_item(OP_WRITE, idx, 8'($urandom), 24'($urandom), 24'($urandom),
						1'($urandom));
				end else begin
					// query, mostly around the grid
					if ($urandom_range(0, 9) == 0) begin
						px = longint'(signed'(24'($urandom)));
						py = longint'(signed'(24'($urandom)));
					end else begin
						px = ox - cs + longint'($urandom % ((cs + 1) * (w + 2) + 1));
						py = oy - cs + longint'($urandom % ((cs + 1) * (h + 2) + 1));
					end
					send_item(OP_QUERY, 16'($urandom), 8'($urandom), clamp_pos(px),
						clamp_pos(py), 1'($urandom));
				end
				items++;
			end
			phase++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d queries and %0d cell writes over %0d map settings",
			n_queries, n_writes, n_phases);
		$display("%0d ray hits seen, %0d queries found an obstacle, %0d errors",
			n_hits, n_summaries_found, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/grcn_pkg.sv
hw/rtl/grcn_div.sv
hw/rtl/grcn_map.sv
hw/rtl/grid_ray_cast_nearest_obstacle_core.sv
dv/tb_top.sv
